/* rtl/rmf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_pkg
// Types, constants and helper functions shared by the RGBA min/max and
// FNV-1a fingerprint block.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int WORD_W   = 32;
    localparam int HASH_W   = 64;
    localparam int NUM_LANES = 4;
    localparam int LANE_W   = 2;

    localparam logic [WORD_W-1:0] POS_INF  = 32'h7f80_0000;
    localparam logic [WORD_W-1:0] NEG_INF  = 32'hff80_0000;
    localparam logic [WORD_W-1:0] EXP_MASK = 32'h7f80_0000;
    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
    // FNV prime is 2^40 + 0x1b3
    localparam int                FNV_SHIFT = 40;
    localparam logic [8:0]        FNV_LOW   = 9'h1b3;

    typedef struct packed {
        logic [NUM_LANES-1:0][WORD_W-1:0] chan;
        logic [NUM_LANES-1:0]             nonfinite;
        logic                             last;
    } pixel_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][WORD_W-1:0] min_val;
        logic [NUM_LANES-1:0][WORD_W-1:0] max_val;
        logic [HASH_W-1:0]                fingerprint;
        logic                             stats_valid;
    } result_t;

    function automatic logic is_nonfinite(input logic [WORD_W-1:0] bits);
        return (bits & EXP_MASK) == EXP_MASK;
    endfunction

    // monotone in float value; -0 and +0 map to the same key
    function automatic logic [WORD_W:0] order_key(input logic [WORD_W-1:0] bits);
        logic [WORD_W:0] mag;
        logic [WORD_W:0] mid;
        mag = {2'b00, bits[WORD_W-2:0]};
        mid = {2'b01, {(WORD_W-1){1'b0}}};
        return bits[WORD_W-1] ? (mid - mag) : (mid + mag);
    endfunction

    // four byte steps of FNV-1a, least significant byte first
    function automatic logic [HASH_W-1:0] fnv_word(input logic [HASH_W-1:0] h,
                                                   input logic [WORD_W-1:0] w);
        logic [HASH_W-1:0] acc;
        acc = h;
        for (int b = 0; b < 4; b++) begin
            acc = acc ^ {56'd0, w[8*b +: 8]};
            acc = (acc << FNV_SHIFT) + (acc * FNV_LOW);
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

/* rtl/rmf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_front
// Accepts pixels, flags nonfinite channels and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module rmf_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [31:0]             red_bits,
    input  wire logic [31:0]             green_bits,
    input  wire logic [31:0]             blue_bits,
    input  wire logic [31:0]             alpha_bits,
    input  wire logic                    last_pixel,
    output logic                         q_valid,
    output rmf_pkg::pixel_t              q_item,
    input  wire logic                    q_pop
);
    import rmf_pkg::*;

    localparam int QDEPTH = 2;

    pixel_t      mem [QDEPTH];
    pixel_t      in_item;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    always_comb
    begin
        in_item.chan[0] = red_bits;
        in_item.chan[1] = green_bits;
        in_item.chan[2] = blue_bits;
        in_item.chan[3] = alpha_bits;
        for (int c = 0; c < NUM_LANES; c++)
        begin
            in_item.nonfinite[c] = is_nonfinite(in_item.chan[c]);
        end
        in_item.last = last_pixel;
    end

    assign full    = (count_reg == 2'(QDEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not grow on push");

endmodule
`default_nettype wire

/* rtl/rmf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_back
// Works one channel per cycle when not stalled or starved: min/max update and
// four FNV-1a byte steps. On the last pixel the result is loaded into the
// output register and the running statistics return to their reset values.
// ----------------------------------------------------------------------------
module rmf_back #(
    parameter int CHANNEL_COUNT = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire rmf_pkg::pixel_t         q_item,
    output logic                         q_pop,
    input  wire logic                    pop,
    output logic                         empty,
    output rmf_pkg::result_t             result
);
    import rmf_pkg::*;

    localparam logic [LANE_W-1:0] LAST_IDX = LANE_W'(CHANNEL_COUNT - 1);

    logic [LANE_W-1:0]                cnt_reg;
    logic [NUM_LANES-1:0][WORD_W-1:0] min_reg;
    logic [NUM_LANES-1:0][WORD_W-1:0] min_next;
    logic [NUM_LANES-1:0][WORD_W-1:0] max_reg;
    logic [NUM_LANES-1:0][WORD_W-1:0] max_next;
    logic [HASH_W-1:0]                hash_reg;
    logic [HASH_W-1:0]                hash_next;
    logic                             bad_reg;
    logic                             bad_next;
    logic                             out_valid_reg;
    result_t                          res_reg;
    result_t                          res_next;
    logic [WORD_W-1:0]                word;
    logic                             word_nf;
    logic                             last_step;
    logic                             stall;
    logic                             advance;
    logic                             finish;

    assign word      = q_item.chan[cnt_reg];
    assign word_nf   = q_item.nonfinite[cnt_reg];
    assign last_step = (cnt_reg == LAST_IDX);
    // finishing an image needs room in the output register
    assign stall     = last_step && q_item.last && out_valid_reg && !pop;
    assign advance   = q_valid && !stall;
    assign finish    = advance && last_step && q_item.last;
    assign q_pop     = advance && last_step;
    assign empty     = !out_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        min_next  = min_reg;
        max_next  = max_reg;
        hash_next = hash_reg;
        bad_next  = bad_reg;
        if (advance)
        begin
            if (word_nf)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                if (order_key(word) < order_key(min_reg[cnt_reg]))
                begin
                    min_next[cnt_reg] = word;
                end
                if (order_key(word) > order_key(max_reg[cnt_reg]))
                begin
                    max_next[cnt_reg] = word;
                end
                hash_next = fnv_word(hash_reg, word);
            end
        end
    end

    always_comb
    begin
        res_next = '0;
        if (!bad_next)
        begin
            for (int c = 0; c < NUM_LANES; c++)
            begin
                if (c < CHANNEL_COUNT)
                begin
                    res_next.min_val[c] = min_next[c];
                    res_next.max_val[c] = max_next[c];
                end
            end
            res_next.fingerprint = hash_next;
            res_next.stats_valid = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            min_reg       <= {NUM_LANES{POS_INF}};
            max_reg       <= {NUM_LANES{NEG_INF}};
            hash_reg      <= FNV_BASIS;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                cnt_reg <= last_step ? '0 : cnt_reg + 1'b1;
            end
            if (finish)
            begin
                min_reg  <= {NUM_LANES{POS_INF}};
                max_reg  <= {NUM_LANES{NEG_INF}};
                hash_reg <= FNV_BASIS;
                bad_reg  <= 1'b0;
            end
            else
            begin
                min_reg  <= min_next;
                max_reg  <= max_next;
                hash_reg <= hash_next;
                bad_reg  <= bad_next;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_IDX)
        else $error("channel counter out of range");

    a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> last_step)
        else $error("queue popped before last channel");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.stats_valid) |-> res_reg.fingerprint == '0)
        else $error("invalid result carries a fingerprint");

    a_reset_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (hash_reg == FNV_BASIS) && !bad_reg && cnt_reg == '0)
        else $error("statistics not cleared after image end");

endmodule
`default_nettype wire

/* rtl/rgba_minmax_fnv1a_fingerprint.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_minmax_fnv1a_fingerprint
// Per-channel float min/max and FNV-1a 64 fingerprint over an RGBA image.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   pixel in | push / full        | red/green/blue/alpha_bits, last_pixel
//   result   | empty / pop        | min_*, max_*, fingerprint, stats_valid
//
// The back end works one channel per cycle while not stalled or starved
// (min/max compare plus four chained FNV byte steps); that loop sets the rate.
// A two-pixel queue decouples the input from the back end.
// The result appears in the cycle after the last channel of the last pixel.
// Reset empties the queue and the output and loads +inf/-inf and the FNV basis.
// The back end stalls on the last pixel only while an unread result is held.
// ----------------------------------------------------------------------------
module rgba_minmax_fnv1a_fingerprint #(
    parameter int CHANNEL_COUNT = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [31:0]  red_bits,
    input  wire logic [31:0]  green_bits,
    input  wire logic [31:0]  blue_bits,
    input  wire logic [31:0]  alpha_bits,
    input  wire logic         last_pixel,
    output logic              empty,
    input  wire logic         pop,
    output logic [31:0]       min_red,
    output logic [31:0]       min_green,
    output logic [31:0]       min_blue,
    output logic [31:0]       min_alpha,
    output logic [31:0]       max_red,
    output logic [31:0]       max_green,
    output logic [31:0]       max_blue,
    output logic [31:0]       max_alpha,
    output logic [63:0]       fingerprint,
    output logic              stats_valid
);
    import rmf_pkg::*;

    logic    q_valid;
    logic    q_pop;
    pixel_t  q_item;
    result_t result;

    rmf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .red_bits   (red_bits),
        .green_bits (green_bits),
        .blue_bits  (blue_bits),
        .alpha_bits (alpha_bits),
        .last_pixel (last_pixel),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    rmf_back #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign min_red     = result.min_val[0];
    assign min_green   = result.min_val[1];
    assign min_blue    = result.min_val[2];
    assign min_alpha   = result.min_val[3];
    assign max_red     = result.max_val[0];
    assign max_green   = result.max_val[1];
    assign max_blue    = result.max_val[2];
    assign max_alpha   = result.max_val[3];
    assign fingerprint = result.fingerprint;
    assign stats_valid = result.stats_valid;

endmodule
`default_nettype wire
